// ----- src/axis_homing_command_sequencer_unit_defines.svh -----
// Assertion macros for the axis homing command sequencer
`ifndef AXIS_HOMING_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define AXIS_HOMING_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// check a consequence in the same cycle
`define AHCS_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ahcs assertion failed");

// check a consequence in the next cycle
`define AHCS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ahcs assertion failed");

`endif

// ----- src/ahcs_pkg.sv -----
// Shared types, codes and constants of the axis homing command sequencer
package ahcs_pkg;

   localparam int UM_W = 23;
   localparam int STEP_W = 20;
   localparam int LIFT_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int MICROSTEPS_DEFAULT = 16;

   // trunc((400*M*um + 99000) / 198000) == trunc((2*M*um + 495) / 990)
   localparam int DIV_BASE = 990;
   localparam int ROUND_BIAS = 495;

   localparam logic signed [STEP_W-1:0] STEP_MAX = 20'sh7FFFF;
   localparam logic signed [STEP_W-1:0] STEP_MIN = 20'sh80000;

   localparam logic [LIFT_W-1:0] LIFT_UP_STEPS_RESET = 16'd5000;
   localparam logic signed [STEP_W-1:0] REFERENCE_TRAVEL_RESET = -20'sd500000;

   localparam logic CSR_LIFT_UP_STEPS = 1'b0;
   localparam logic CSR_REFERENCE_TRAVEL = 1'b1;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [2:0] CMD_STOP = 3'd0;
   localparam logic [2:0] CMD_REFERENCE = 3'd1;
   localparam logic [2:0] CMD_MOVE = 3'd2;
   localparam logic [2:0] CMD_UP = 3'd3;
   localparam logic [2:0] CMD_DOWN = 3'd4;
   localparam logic [2:0] CMD_CLEAR_FAULTS = 3'd5;

   localparam logic [2:0] RUN_IDLE = 3'd0;
   localparam logic [2:0] RUN_REFERENCE = 3'd1;
   localparam logic [2:0] RUN_MOVE = 3'd2;
   localparam logic [2:0] RUN_UP = 3'd3;
   localparam logic [2:0] RUN_DOWN = 3'd4;

   localparam logic [1:0] ORDER_NONE = 2'd0;
   localparam logic [1:0] ORDER_SLEDGE_REL = 2'd1;
   localparam logic [1:0] ORDER_SLEDGE_ABS = 2'd2;
   localparam logic [1:0] ORDER_LIFT_ABS = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_NO_REFERENCE = 2'd1;
   localparam logic [1:0] ERR_BLOCKED = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN_CMD = 2'd3;

   typedef struct packed {
      logic kind;
      logic [2:0] command;
      logic signed [UM_W-1:0] position_um;
      logic motors_done;
      logic motor_blocked;
      logic ref_sensor_raw;
   } item_type;

   typedef struct packed {
      logic stop_all;
      logic reset_motors;
      logic [1:0] move_order;
      logic signed [STEP_W-1:0] move_steps;
      logic clear_faults;
      logic [1:0] error_code;
      logic [2:0] active_command;
      logic is_moving;
      logic homed;
      logic at_reference;
      logic lift_is_up;
      logic lift_is_down;
   } result_type;

   typedef struct packed {
      logic [LIFT_W-1:0] lift_up_steps;
      logic signed [STEP_W-1:0] reference_travel;
   } cfg_type;

endpackage

// ----- src/ahcs_csr.sv -----
// Configuration register file with APB-style access
module ahcs_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [ahcs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ahcs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ahcs_pkg::CSR_DATA_W-1:0] prdata,
   output ahcs_pkg::cfg_type cfg
);

   logic [ahcs_pkg::LIFT_W-1:0] lift_up_steps_ff;
   logic signed [ahcs_pkg::STEP_W-1:0] reference_travel_ff;
   logic wr_en;
   logic reg_idx;

   assign wr_en = psel & penable & pwrite;
   assign reg_idx = paddr[ahcs_pkg::CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_up_steps_ff <= ahcs_pkg::LIFT_UP_STEPS_RESET;
         reference_travel_ff <= ahcs_pkg::REFERENCE_TRAVEL_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            ahcs_pkg::CSR_LIFT_UP_STEPS: begin
               lift_up_steps_ff <= pwdata[ahcs_pkg::LIFT_W-1:0];
            end
            ahcs_pkg::CSR_REFERENCE_TRAVEL: begin
               reference_travel_ff <= $signed(pwdata[ahcs_pkg::STEP_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ahcs_pkg::CSR_LIFT_UP_STEPS: begin
            prdata = ahcs_pkg::CSR_DATA_W'(lift_up_steps_ff);
         end
         ahcs_pkg::CSR_REFERENCE_TRAVEL: begin
            prdata = ahcs_pkg::CSR_DATA_W'(reference_travel_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.lift_up_steps = lift_up_steps_ff;
   assign cfg.reference_travel = reference_travel_ff;

endmodule

// ----- src/ahcs_conv.sv -----
// Input register and pipelined micrometre to step conversion
module ahcs_conv #(
   parameter int MICROSTEPS = ahcs_pkg::MICROSTEPS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  ahcs_pkg::item_type in_item,
   output logic out_valid,
   output ahcs_pkg::item_type out_item,
   output logic signed [ahcs_pkg::STEP_W-1:0] out_steps
);

   localparam int SCALE = 2 * MICROSTEPS;
   localparam int SCALE_W = $clog2(SCALE + 1);
   localparam int NUM_W = ahcs_pkg::UM_W + SCALE_W + 1;
   localparam int MAG_W = NUM_W - 1;
   localparam int RECIP_SHIFT = MAG_W + 9;
   localparam longint unsigned RECIP_L = (64'd1 << RECIP_SHIFT) / 64'd990;
   localparam logic [MAG_W-1:0] RECIP = MAG_W'(RECIP_L);
   localparam int Q_W = MAG_W - 9;
   localparam int SAT_W = (Q_W + 1 > ahcs_pkg::STEP_W + 1) ? Q_W + 1 : ahcs_pkg::STEP_W + 1;

   logic s1_valid_ff;
   ahcs_pkg::item_type s1_item_ff;
   logic s2_valid_ff;
   ahcs_pkg::item_type s2_item_ff;
   logic s2_neg_ff;
   logic [MAG_W-1:0] s2_mag_ff;
   logic s3_valid_ff;
   ahcs_pkg::item_type s3_item_ff;
   logic s3_neg_ff;
   logic [MAG_W-1:0] s3_mag_ff;
   logic [Q_W-1:0] s3_quot_ff;
   logic s4_valid_ff;
   ahcs_pkg::item_type s4_item_ff;
   logic signed [ahcs_pkg::STEP_W-1:0] s4_steps_ff;

   logic signed [NUM_W-1:0] num;
   logic [MAG_W-1:0] s2_mag_in;
   logic [2*MAG_W-1:0] prod_wide;
   logic [Q_W-1:0] s3_quot_in;
   logic [MAG_W:0] back_prod;
   logic [MAG_W:0] remainder;
   logic [Q_W-1:0] quot;
   logic signed [SAT_W-1:0] sval;
   logic signed [ahcs_pkg::STEP_W-1:0] s4_steps_in;

   assign num = NUM_W'(s1_item_ff.position_um) * $signed(NUM_W'(SCALE))
      + $signed(NUM_W'(ahcs_pkg::ROUND_BIAS));
   assign s2_mag_in = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

   assign prod_wide = (2 * MAG_W)'(s2_mag_ff) * (2 * MAG_W)'(RECIP);
   assign s3_quot_in = prod_wide[RECIP_SHIFT +: Q_W];

   always_comb begin
      back_prod = (MAG_W + 1)'(s3_quot_ff) * (MAG_W + 1)'(ahcs_pkg::DIV_BASE);
      remainder = (MAG_W + 1)'(s3_mag_ff) - back_prod;
      quot = (remainder >= (MAG_W + 1)'(ahcs_pkg::DIV_BASE)) ? s3_quot_ff + 1'b1 : s3_quot_ff;
      sval = s3_neg_ff ? -$signed(SAT_W'(quot)) : $signed(SAT_W'(quot));
      if (sval > SAT_W'(ahcs_pkg::STEP_MAX)) begin
         s4_steps_in = ahcs_pkg::STEP_MAX;
      end else if (sval < SAT_W'(ahcs_pkg::STEP_MIN)) begin
         s4_steps_in = ahcs_pkg::STEP_MIN;
      end else begin
         s4_steps_in = sval[ahcs_pkg::STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= in_item;
         s2_item_ff <= s1_item_ff;
         s2_neg_ff <= num[NUM_W-1];
         s2_mag_ff <= s2_mag_in;
         s3_item_ff <= s2_item_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_quot_ff <= s3_quot_in;
         s4_item_ff <= s3_item_ff;
         s4_steps_ff <= s4_steps_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item = s4_item_ff;
   assign out_steps = s4_steps_ff;

endmodule

// ----- src/ahcs_ctrl.sv -----
// Sequencer state, command decode and result register
module ahcs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  ahcs_pkg::item_type in_item,
   input  logic signed [ahcs_pkg::STEP_W-1:0] in_steps,
   input  ahcs_pkg::cfg_type cfg,
   output logic rsp_valid,
   output ahcs_pkg::result_type rsp
);

   logic [2:0] running_ff;
   logic moving_ff;
   logic homed_ff;
   logic at_ref_ff;
   logic up_ff;
   logic down_ff;
   logic signed [ahcs_pkg::STEP_W-1:0] pending_ff;
   logic signed [ahcs_pkg::STEP_W-1:0] current_ff;
   logic rsp_valid_ff;
   ahcs_pkg::result_type rsp_ff;

   logic [2:0] running_in;
   logic moving_in;
   logic homed_in;
   logic at_ref_in;
   logic up_in;
   logic down_in;
   logic signed [ahcs_pkg::STEP_W-1:0] pending_in;
   logic signed [ahcs_pkg::STEP_W-1:0] current_in;
   ahcs_pkg::result_type rsp_in;

   always_comb begin
      logic signed [ahcs_pkg::STEP_W-1:0] lift_ext;
      logic lift_blocked;
      logic sensor_on;
      logic homed_t;
      logic signed [ahcs_pkg::STEP_W-1:0] pend_t;

      lift_ext = $signed(ahcs_pkg::STEP_W'(cfg.lift_up_steps));
      lift_blocked = (in_item.command == ahcs_pkg::CMD_UP) ? up_ff : down_ff;
      sensor_on = ~in_item.ref_sensor_raw;
      homed_t = homed_ff;
      pend_t = pending_ff;

      running_in = running_ff;
      moving_in = moving_ff;
      homed_in = homed_ff;
      at_ref_in = at_ref_ff;
      up_in = up_ff;
      down_in = down_ff;
      pending_in = pending_ff;
      current_in = current_ff;
      rsp_in = '0;

      if (in_item.kind == ahcs_pkg::KIND_COMMAND) begin
         case (in_item.command)
            ahcs_pkg::CMD_STOP: begin
               rsp_in.stop_all = 1'b1;
               running_in = ahcs_pkg::RUN_IDLE;
               homed_in = 1'b0;
            end
            ahcs_pkg::CMD_REFERENCE: begin
               pending_in = '0;
               rsp_in.stop_all = 1'b1;
               running_in = ahcs_pkg::RUN_REFERENCE;
               moving_in = 1'b1;
               rsp_in.move_order = ahcs_pkg::ORDER_SLEDGE_REL;
               rsp_in.move_steps = cfg.reference_travel;
            end
            ahcs_pkg::CMD_MOVE: begin
               if (running_ff == ahcs_pkg::RUN_IDLE && (in_steps != current_ff || !homed_ff))
               begin
                  pending_in = in_steps;
                  moving_in = 1'b1;
                  if (homed_ff) begin
                     running_in = ahcs_pkg::RUN_MOVE;
                     rsp_in.move_order = ahcs_pkg::ORDER_SLEDGE_ABS;
                     rsp_in.move_steps = in_steps;
                  end else begin
                     rsp_in.stop_all = 1'b1;
                     running_in = ahcs_pkg::RUN_REFERENCE;
                     rsp_in.move_order = ahcs_pkg::ORDER_SLEDGE_REL;
                     rsp_in.move_steps = cfg.reference_travel;
                  end
               end
            end
            ahcs_pkg::CMD_UP, ahcs_pkg::CMD_DOWN: begin
               if (running_ff == ahcs_pkg::RUN_IDLE && !lift_blocked) begin
                  running_in = in_item.command;
                  moving_in = 1'b1;
                  rsp_in.move_order = ahcs_pkg::ORDER_LIFT_ABS;
                  rsp_in.move_steps = (in_item.command == ahcs_pkg::CMD_UP) ? lift_ext : -lift_ext;
               end
            end
            ahcs_pkg::CMD_CLEAR_FAULTS: begin
               rsp_in.clear_faults = 1'b1;
            end
            default: begin
               rsp_in.error_code = ahcs_pkg::ERR_UNKNOWN_CMD;
            end
         endcase
      end else begin
         if (moving_ff) begin
            at_ref_in = 1'b0;
            up_in = 1'b0;
            down_in = 1'b0;
         end
         if (running_ff == ahcs_pkg::RUN_IDLE) begin
            moving_in = 1'b0;
         end
         if (running_ff != ahcs_pkg::RUN_IDLE && in_item.motors_done) begin
            moving_in = 1'b0;
            if (running_ff == ahcs_pkg::RUN_REFERENCE) begin
               if (!sensor_on) begin
                  rsp_in.error_code = ahcs_pkg::ERR_NO_REFERENCE;
               end
               homed_t = sensor_on;
               rsp_in.reset_motors = 1'b1;
            end else if (in_item.motor_blocked) begin
               rsp_in.error_code = ahcs_pkg::ERR_BLOCKED;
               homed_t = 1'b0;
            end
            if (running_ff == ahcs_pkg::RUN_MOVE) begin
               current_in = pending_ff;
               pend_t = '0;
            end
            at_ref_in = (running_ff == ahcs_pkg::RUN_REFERENCE) && homed_t;
            up_in = (running_ff == ahcs_pkg::RUN_UP) && homed_t;
            down_in = (running_ff == ahcs_pkg::RUN_DOWN) && homed_t;
            if (homed_t && running_ff == ahcs_pkg::RUN_REFERENCE && pend_t != '0) begin
               running_in = ahcs_pkg::RUN_MOVE;
               moving_in = 1'b1;
               rsp_in.move_order = ahcs_pkg::ORDER_SLEDGE_ABS;
               rsp_in.move_steps = pend_t;
            end else begin
               running_in = ahcs_pkg::RUN_IDLE;
            end
            homed_in = homed_t;
            pending_in = pend_t;
         end
      end

      rsp_in.active_command = running_in;
      rsp_in.is_moving = moving_in;
      rsp_in.homed = homed_in;
      rsp_in.at_reference = at_ref_in;
      rsp_in.lift_is_up = up_in;
      rsp_in.lift_is_down = down_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= ahcs_pkg::RUN_IDLE;
         moving_ff <= 1'b0;
         homed_ff <= 1'b0;
         at_ref_ff <= 1'b0;
         up_ff <= 1'b0;
         down_ff <= 1'b0;
         pending_ff <= '0;
         current_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= in_valid;
         if (in_valid) begin
            running_ff <= running_in;
            moving_ff <= moving_in;
            homed_ff <= homed_in;
            at_ref_ff <= at_ref_in;
            up_ff <= up_in;
            down_ff <= down_in;
            pending_ff <= pending_in;
            current_ff <= current_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ----- src/axis_homing_command_sequencer_unit.sv -----
// Top level of the axis homing command sequencer
//
//   channel  direction  handshake              beat
//   req      in         req_valid/req_ready    one command or status tick
//   rsp      out        rsp_valid/rsp_ready    one result per req beat
//   csr      in/out     csr_psel/csr_penable   one register write or read
//
// One beat per cycle while rsp is not stalled; each beat passes from req to rsp through
// an input register, three stages of the micrometre to step conversion
// (multiply by scale, multiply by reciprocal, correct and saturate) and the
// result register written by the state update.
// Reset is synchronous, clears all control state and sets both configuration registers to their reset values.
// A stalled rsp holds the whole pipeline and drops req_ready.
`include "axis_homing_command_sequencer_unit_defines.svh"

module axis_homing_command_sequencer_unit #(
   parameter int MICROSTEPS = ahcs_pkg::MICROSTEPS_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   input  logic [2:0] req_command,
   input  logic signed [ahcs_pkg::UM_W-1:0] req_position_um,
   input  logic req_motors_done,
   input  logic req_motor_blocked,
   input  logic req_ref_sensor_raw,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_stop_all,
   output logic rsp_reset_motors,
   output logic [1:0] rsp_move_order,
   output logic signed [ahcs_pkg::STEP_W-1:0] rsp_move_steps,
   output logic rsp_clear_faults,
   output logic [1:0] rsp_error_code,
   output logic [2:0] rsp_active_command,
   output logic rsp_is_moving,
   output logic rsp_homed,
   output logic rsp_at_reference,
   output logic rsp_lift_is_up,
   output logic rsp_lift_is_down,

   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ahcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ahcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ahcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic en;
   ahcs_pkg::item_type req_item;
   ahcs_pkg::cfg_type cfg;
   logic conv_valid;
   ahcs_pkg::item_type conv_item;
   logic signed [ahcs_pkg::STEP_W-1:0] conv_steps;
   ahcs_pkg::result_type rsp;

   assign en = ~rsp_valid | rsp_ready;
   assign req_ready = en;
   assign csr_pready = 1'b1;

   assign req_item.kind = req_kind;
   assign req_item.command = req_command;
   assign req_item.position_um = req_position_um;
   assign req_item.motors_done = req_motors_done;
   assign req_item.motor_blocked = req_motor_blocked;
   assign req_item.ref_sensor_raw = req_ref_sensor_raw;

   ahcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   ahcs_conv #(
      .MICROSTEPS (MICROSTEPS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (conv_valid),
      .out_item  (conv_item),
      .out_steps (conv_steps)
   );

   ahcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (conv_valid),
      .in_item   (conv_item),
      .in_steps  (conv_steps),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_stop_all = rsp.stop_all;
   assign rsp_reset_motors = rsp.reset_motors;
   assign rsp_move_order = rsp.move_order;
   assign rsp_move_steps = rsp.move_steps;
   assign rsp_clear_faults = rsp.clear_faults;
   assign rsp_error_code = rsp.error_code;
   assign rsp_active_command = rsp.active_command;
   assign rsp_is_moving = rsp.is_moving;
   assign rsp_homed = rsp.homed;
   assign rsp_at_reference = rsp.at_reference;
   assign rsp_lift_is_up = rsp.lift_is_up;
   assign rsp_lift_is_down = rsp.lift_is_down;

   `AHCS_ASSERT_NOW(a_lift_flags_exclusive, rsp_valid, !(rsp_lift_is_up && rsp_lift_is_down))
   `AHCS_ASSERT_NOW(a_no_ref_resets, rsp_valid && rsp_error_code == ahcs_pkg::ERR_NO_REFERENCE, rsp_reset_motors)
   `AHCS_ASSERT_NOW(a_idle_order_zero, rsp_valid && rsp_move_order == ahcs_pkg::ORDER_NONE, rsp_move_steps == '0)
   `AHCS_ASSERT_NOW(a_lift_order_cmd, rsp_valid && rsp_move_order == ahcs_pkg::ORDER_LIFT_ABS, rsp_active_command == ahcs_pkg::RUN_UP || rsp_active_command == ahcs_pkg::RUN_DOWN)
   `AHCS_ASSERT_NEXT(a_bubble_no_rsp, en && !conv_valid, !rsp_valid)

endmodule
